// ----- rtl/tks_pkg.sv -----
`timescale 1ns / 1ps

package tks_pkg;

  // Sizing
  localparam int MAX_KEEP   = 16;
  localparam int MAX_ITEMS  = 1048576;
  localparam int SCORE_W    = 32;
  localparam int ID_W       = 20;
  localparam int RANK_W     = 4;
  localparam int KEEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Drain counter: holds a rank 0 .. MAX_KEEP-1
  localparam int CNT_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CMP_W = ((CNT_W > KEEP_W) ? CNT_W : KEEP_W) + 1;

  // Ids stop at the smaller of the stream limit and the id field range
  localparam int ID_LIMIT_INT = (MAX_ITEMS - 1 < (1 << ID_W) - 1) ?
                                (MAX_ITEMS - 1) : ((1 << ID_W) - 1);
  localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(ID_LIMIT_INT);

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_DESC = CFG_IDX_W'(1);

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = KEEP_W'(16);

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } entry_t;

  typedef struct packed {
    logic insert;      // a new pair enters the chain this cycle
    logic drain;       // chain moves one place towards the head
    logic clear;       // query finished, drop every entry
    logic descending;  // angular ordering
  } cell_ctrl_t;

  // True when (s, id) ranks ahead of (ks, kid)
  function automatic logic beats(input logic signed [SCORE_W-1:0] s,
                                 input logic [ID_W-1:0]           id,
                                 input logic signed [SCORE_W-1:0] ks,
                                 input logic [ID_W-1:0]           kid,
                                 input logic                      desc);
    logic res;
    if (desc) begin
      res = (s > ks) || ((s == ks) && (id > kid));
    end else begin
      res = (s < ks) || ((s == ks) && (id < kid));
    end
    return res;
  endfunction

endpackage

// ----- rtl/tks_ifs.sv -----
`timescale 1ns / 1ps

interface tks_in_if import tks_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last_item;

  modport source (output valid, score, last_item, input ready);
  modport sink   (input valid, score, last_item, output ready);
endinterface

interface tks_out_if import tks_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] best_score;
  logic [ID_W-1:0]           item_id;
  logic [RANK_W-1:0]         rank;
  logic                      last_result;

  modport source (output valid, best_score, item_id, rank, last_result, input ready);
  modport sink   (input valid, best_score, item_id, rank, last_result, output ready);
endinterface

interface tks_cfg_if import tks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tks_cell.sv -----
`timescale 1ns / 1ps

module tks_cell import tks_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctrl_t                ctrl,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic [ID_W-1:0]           new_id,
  input  entry_t                    prev_entry,
  input  entry_t                    next_entry,
  input  logic                      found_in,
  output entry_t                    entry,
  output logic                      found_out
);

  logic                      valid;
  logic signed [SCORE_W-1:0] score;
  logic [ID_W-1:0]           id;
  logic                      take;

  // An empty slot or a beaten pair marks the insertion point
  assign take      = !valid || beats(new_score, new_id, score, id, ctrl.descending);
  assign found_out = found_in | take;
  assign entry     = '{valid: valid, score: score, id: id};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (found_in) begin
        valid <= prev_entry.valid;
      end else if (take) begin
        valid <= 1'b1;
      end
    end else if (ctrl.drain) begin
      valid <= next_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (found_in) begin
        score <= prev_entry.score;
        id    <= prev_entry.id;
      end else if (take) begin
        score <= new_score;
        id    <= new_id;
      end
    end else if (ctrl.drain) begin
      score <= next_entry.score;
      id    <= next_entry.id;
    end
  end

endmodule

// ----- rtl/top_k_select_stream.sv -----
`timescale 1ns / 1ps
// Input: one score transaction per cycle while no result list is being drained.
// Latency: first result is offered the cycle after the transaction marked last.
// Drain: min(keep_count, items seen, MAX_KEEP) results (0 acts as 1), one per
//   ready cycle, the chain shifting one cell headwards on every accepted result.
// Reset (rst, synchronous): all kept pairs invalid, id counter 0, keep_count 16,
//   euclidean order. No clearing pass.

module top_k_select_stream import tks_pkg::*; (
  input logic clk,
  input logic rst,
  tks_in_if.sink    items,
  tks_out_if.source results,
  tks_cfg_if.sink   cfg
);

  // Configuration registers
  logic [KEEP_W-1:0] keep_count;
  logic              order_desc;

  // Query state
  logic              draining;
  logic [CNT_W-1:0]  cnt;
  logic [ID_W-1:0]   item_counter;

  logic              in_acc;
  logic              out_acc;
  logic              last_res;
  cell_ctrl_t        ctrl;

  // Cell i sits at index i; index 0 and MAX_KEEP+1 are empty ends of the chain
  entry_t            cell_q [0:MAX_KEEP+1];
  logic [MAX_KEEP:0] found;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_COUNT_RESET;
      order_desc <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_KEEP_COUNT: keep_count <= cfg.data[KEEP_W-1:0];
        REG_ORDER_DESC: order_desc <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Handshakes: scores are held off while the list drains
  assign items.ready = !draining;
  assign in_acc      = items.valid && items.ready;
  assign out_acc     = results.valid && results.ready;

  // Final result: next cell empty, or keep_count reached (0 behaves as 1)
  assign last_res = !cell_q[2].valid ||
                    ((CMP_W'(cnt) + CMP_W'(1)) >= CMP_W'(keep_count));

  assign ctrl = '{insert:     in_acc,
                  drain:      out_acc,
                  clear:      out_acc && last_res,
                  descending: order_desc};

  assign cell_q[0]          = '0;
  assign cell_q[MAX_KEEP+1] = '0;
  assign found[0]           = 1'b0;

  // Insertion chain: each cell compares the broadcast pair with its own and
  // either keeps, takes the new pair, or takes its left neighbour's pair.
  for (genvar i = 1; i <= MAX_KEEP; i++) begin : g_cell
    tks_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_score  (items.score),
      .new_id     (item_counter),
      .prev_entry (cell_q[i-1]),
      .next_entry (cell_q[i+1]),
      .found_in   (found[i-1]),
      .entry      (cell_q[i]),
      .found_out  (found[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining     <= 1'b0;
      cnt          <= '0;
      item_counter <= '0;
    end else begin
      if (in_acc) begin
        if (items.last_item) begin
          draining     <= 1'b1;
          item_counter <= '0;
        end else if (item_counter != ID_LIMIT) begin
          item_counter <= item_counter + ID_W'(1);
        end
      end
      if (out_acc) begin
        if (last_res) begin
          draining <= 1'b0;
          cnt      <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // Results come straight from the head cell
  assign results.valid       = draining;
  assign results.best_score  = cell_q[1].score;
  assign results.item_id     = cell_q[1].id;
  assign results.rank        = RANK_W'(cnt);
  assign results.last_result = last_res;

endmodule

// ----- rtl/tks_checker.sv -----
`timescale 1ns / 1ps

module tks_checker import tks_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [RANK_W-1:0] out_rank
);

  // No score taken while results are offered
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("score accepted during drain");

  // Query end starts the drain next cycle
  a_drain_follows_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> out_valid)
    else $error("no result after final score");

  // Result list begins at rank zero
  a_first_rank_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_rank == '0))
    else $error("first result not rank zero");

  // Ranks advance by one until the final result
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_rank == $past(out_rank) + RANK_W'(1))))
    else $error("rank sequence broken");

  // Final result closes the list
  a_end_of_list: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("results continue after final");

endmodule

bind top_k_select_stream tks_checker u_tks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_last   (items.last_item),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_last  (results.last_result),
  .out_rank  (results.rank)
);
